### sv/sfir_pkg.sv
// Shared types and constants for the decimating FIR core.
// Holds the item structs, the command queue entry, the configuration
// register set and the register map. No dependencies.
package sfir_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SAMPLE_MAX  = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam int INDEX_BITS  = 7;

    // Register map, in units of 32-bit words
    localparam logic [1:0] REG_TAP_COUNT    = 2'd0;
    localparam logic [1:0] REG_DECIM        = 2'd1;
    localparam logic [1:0] REG_SQUARE_INPUT = 2'd2;
    localparam logic [1:0] REG_GAIN         = 2'd3;

    localparam logic [7:0] TAP_COUNT_RESET = 8'd101;
    localparam logic [5:0] DECIM_RESET     = 6'd10;
    localparam logic [5:0] GAIN_RESET      = 6'd1;

    typedef struct packed {
        logic                          cmd;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [INDEX_BITS-1:0]         coef_index;
        logic signed [SAMPLE_BITS-1:0] coef_value;
    } sfir_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic                          clipped;
    } sfir_out_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } sfir_op_t;

    typedef struct packed {
        sfir_op_t                      op;
        logic signed [SAMPLE_BITS-1:0] data;
        logic [INDEX_BITS-1:0]         index;
    } sfir_cmd_t;

    typedef struct packed {
        logic [7:0] tap_count;
        logic [5:0] decim;
        logic       square_input;
        logic [5:0] gain;
    } sfir_cfg_t;

endpackage

### sv/sfir_fifo.sv
// Small register-based queue with push/full and pop/empty sides.
// Used for the command queue and the result queue; no dependencies.
module sfir_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/sfir_front.sv
// Front end: accepts input items, classifies them into commands and
// queues them for the back end. Depends on sfir_pkg and sfir_fifo.
module sfir_front #(
    parameter int MAX_TAPS = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sfir_pkg::sfir_in_t  data,
    output logic                cq_empty,
    input  logic                cq_pop,
    output sfir_pkg::sfir_cmd_t cq_item
);
    import sfir_pkg::*;

    sfir_cmd_t cmd_in;
    logic      keep;
    logic      q_full;

    // Drop coefficient loads aimed beyond the implemented taps
    always_comb
    begin
        if (data.cmd)
        begin
            cmd_in.op    = OP_LOAD;
            cmd_in.data  = data.coef_value;
            cmd_in.index = data.coef_index;
            keep         = (32'(data.coef_index) < 32'(MAX_TAPS));
        end
        else
        begin
            cmd_in.op    = OP_SAMPLE;
            cmd_in.data  = data.sample;
            cmd_in.index = data.coef_index;
            keep         = 1'b1;
        end
    end

    assign full = q_full;

    sfir_fifo #(
        .WIDTH ($bits(sfir_cmd_t)),
        .DEPTH (4)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .full  (q_full),
        .wdata (cmd_in),
        .pop   (cq_pop),
        .empty (cq_empty),
        .rdata (cq_item)
    );

endmodule

### sv/sfir_back.sv
// Back end: executes queued commands. Holds the coefficient and delay-line
// memories, the phase counter and one shared multiplier used for squaring
// and for the tap-serial multiply-accumulate. Depends on sfir_pkg.
module sfir_back #(
    parameter int MAX_TAPS = 128,
    parameter int ACC_BITS = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sfir_pkg::sfir_cfg_t cfg,
    input  logic                cq_empty,
    output logic                cq_pop,
    input  sfir_pkg::sfir_cmd_t cq_item,
    output logic                res_push,
    input  logic                res_full,
    output sfir_pkg::sfir_out_t res_item
);
    import sfir_pkg::*;

    localparam int AW  = $clog2(MAX_TAPS);
    localparam int CW  = $clog2(MAX_TAPS + 1);
    localparam int PW  = 2 * SAMPLE_BITS;
    localparam int SW  = ((ACC_BITS > PW) ? ACC_BITS : PW) + 1;
    localparam int SHW = ACC_BITS - (SAMPLE_BITS - 1);
    localparam int GW  = 7;
    localparam int YW  = SHW + GW;

    localparam logic signed [SW-1:0] ACC_MAX = SW'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic signed [YW-1:0] Y_MAX   = YW'(SAMPLE_MAX);
    localparam logic signed [YW-1:0] Y_MIN   = YW'(SAMPLE_MIN);
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = SAMPLE_BITS'(SAMPLE_MAX);
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = SAMPLE_BITS'(SAMPLE_MIN);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_WR    = 7'b0000100,
        S_MAC   = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_SAT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] dly_mem  [MAX_TAPS];

    // control state
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] tap_reg, tap_next;
    logic [CW-1:0] taps_reg, taps_next;
    logic [4:0]    phase_reg, phase_next;
    logic          v1_reg, v2_reg, ok1_reg;

    // datapath
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] coef_q_reg;
    logic signed [SAMPLE_BITS-1:0] dly_q_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [YW-1:0]          y_reg;

    logic                          coef_we;
    logic                          mac_issue;
    logic                          emit;
    logic signed [SAMPLE_BITS-1:0] mul_a, mul_b;
    logic signed [SAMPLE_BITS-1:0] sq_val, wr_val;
    logic [CW-1:0]                 taps_clamp;
    logic [5:0]                    decim_clamp;
    logic [5:0]                    phase_inc;
    logic signed [SW-1:0]          acc_sum;
    logic signed [ACC_BITS-1:0]    acc_sat;
    logic signed [SHW-1:0]         acc_sh;
    logic signed [GW-1:0]          gain_s;

    // config decode
    always_comb
    begin
        if (32'(cfg.tap_count) > 32'(MAX_TAPS))
        begin
            taps_clamp = CW'(MAX_TAPS);
        end
        else if (cfg.tap_count == 8'd0)
        begin
            taps_clamp = CW'(1);
        end
        else
        begin
            taps_clamp = CW'(cfg.tap_count);
        end

        if (cfg.decim == 6'd0)
        begin
            decim_clamp = 6'd1;
        end
        else if (cfg.decim > 6'd32)
        begin
            decim_clamp = 6'd32;
        end
        else
        begin
            decim_clamp = cfg.decim;
        end
    end

    assign phase_inc = {1'b0, phase_reg} + 6'd1;
    assign emit      = (phase_reg == 5'd0);

    // square: product of 2^30 at most, only the most negative input reaches it
    assign sq_val = prod_reg[PW-2] ? S_MAX : prod_reg[PW-2:SAMPLE_BITS-1];
    assign wr_val = cfg.square_input ? sq_val : x_reg;

    assign mul_a = (state_reg == S_SQ) ? x_reg : coef_q_reg;
    assign mul_b = (state_reg == S_SQ) ? x_reg : (ok1_reg ? dly_q_reg : '0);

    // saturating accumulate
    always_comb
    begin
        acc_sum = SW'(acc_reg) + SW'(prod_reg);
        if (acc_sum > ACC_MAX)
        begin
            acc_sat = ACC_MAX[ACC_BITS-1:0];
        end
        else if (acc_sum < ACC_MIN)
        begin
            acc_sat = ACC_MIN[ACC_BITS-1:0];
        end
        else
        begin
            acc_sat = acc_sum[ACC_BITS-1:0];
        end
    end

    assign acc_sh = acc_reg[ACC_BITS-1:SAMPLE_BITS-1];
    assign gain_s = {1'b0, cfg.gain};

    // final saturation to the sample range
    always_comb
    begin
        if (y_reg > Y_MAX)
        begin
            res_item.filtered = S_MAX;
            res_item.clipped  = 1'b1;
        end
        else if (y_reg < Y_MIN)
        begin
            res_item.filtered = S_MIN;
            res_item.clipped  = 1'b1;
        end
        else
        begin
            res_item.filtered = y_reg[SAMPLE_BITS-1:0];
            res_item.clipped  = 1'b0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        tap_next    = tap_reg;
        taps_next   = taps_reg;
        phase_next  = phase_reg;
        cq_pop      = 1'b0;
        coef_we     = 1'b0;
        mac_issue   = 1'b0;
        res_push    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cq_empty)
                begin
                    cq_pop = 1'b1;
                    if (cq_item.op == OP_LOAD)
                    begin
                        coef_we = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                wp_next = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg != CW'(MAX_TAPS))
                begin
                    fill_next = fill_reg + 1'b1;
                end
                phase_next = (phase_inc >= decim_clamp) ? 5'd0 : phase_inc[4:0];
                if (emit)
                begin
                    rd_ptr_next = wp_reg;
                    tap_next    = '0;
                    taps_next   = taps_clamp;
                    state_next  = S_MAC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MAC:
            begin
                mac_issue   = 1'b1;
                tap_next    = tap_reg + 1'b1;
                rd_ptr_next = (rd_ptr_reg == '0) ? AW'(MAX_TAPS - 1) : rd_ptr_reg - 1'b1;
                if (tap_reg == taps_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the last products to land in the accumulator
                if (!v1_reg && !v2_reg)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wp_reg     <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            tap_reg    <= '0;
            taps_reg   <= '0;
            phase_reg  <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            tap_reg    <= tap_next;
            taps_reg   <= taps_next;
            phase_reg  <= phase_next;
            v1_reg     <= mac_issue;
            v2_reg     <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[AW'(cq_item.index)] <= cq_item.data;
        end
        if (mac_issue)
        begin
            coef_q_reg <= coef_mem[tap_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR)
        begin
            dly_mem[wp_reg] <= wr_val;
        end
        if (mac_issue)
        begin
            dly_q_reg <= dly_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cq_pop)
        begin
            x_reg <= cq_item.data;
        end
        // taps never written since reset read as zero
        ok1_reg  <= (tap_reg < fill_reg);
        prod_reg <= mul_a * mul_b;
        if (state_reg == S_WR)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_sat;
        end
        if (state_reg == S_SCALE)
        begin
            y_reg <= acc_sh * gain_s;
        end
    end

endmodule

### sv/stateful_decimating_fir_core.sv
// Top level of the decimating FIR core: configuration registers, front end,
// back end and result queue. Depends on sfir_pkg, sfir_front, sfir_back
// and sfir_fifo.
//
// Usage:
//   Items enter through push/full: cmd 0 feeds a sample, cmd 1 loads the
//   coefficient at coef_index. Results leave through empty/pop; the oldest
//   result sits on the result port while empty is low.
//   A four-entry command queue sits between intake and execution, and a
//   two-entry result queue after it, so intake continues while a result
//   waits to be taken.
//   A coefficient load is done in the idle state. A sample that gives no
//   result passes the square and write states; one that gives a result
//   then runs the MAC state once per tap, the shared multiplier handling
//   one tap per cycle, then drain, scale and saturate, where the result
//   enters the result queue; it can be popped at the edge after that.
//   When the result queue is full, the back end holds its finished result
//   and the command queue fills; full then rises.
//   Reset clears the phase, the delay line (through a fill count, so no
//   clearing pass) and the registers to their defaults; coefficients are
//   undefined until loaded. Write registers only while the block is idle.
module stateful_decimating_fir_core #(
    parameter int MAX_TAPS = 128,
    parameter int ACC_BITS = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sfir_pkg::sfir_in_t  data,
    output logic                empty,
    input  logic                pop,
    output sfir_pkg::sfir_out_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sfir_pkg::*;

    sfir_cfg_t cfg_reg;
    sfir_cmd_t cq_item;
    sfir_out_t res_item;
    logic      cq_empty;
    logic      cq_pop;
    logic      res_push;
    logic      res_full;
    logic      cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_count    <= TAP_COUNT_RESET;
            cfg_reg.decim        <= DECIM_RESET;
            cfg_reg.square_input <= 1'b0;
            cfg_reg.gain         <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_TAP_COUNT:    cfg_reg.tap_count    <= pwdata[7:0];
                REG_DECIM:        cfg_reg.decim        <= pwdata[5:0];
                REG_SQUARE_INPUT: cfg_reg.square_input <= pwdata[0];
                REG_GAIN:         cfg_reg.gain         <= pwdata[5:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TAP_COUNT:    prdata = 32'(cfg_reg.tap_count);
            REG_DECIM:        prdata = 32'(cfg_reg.decim);
            REG_SQUARE_INPUT: prdata = 32'(cfg_reg.square_input);
            REG_GAIN:         prdata = 32'(cfg_reg.gain);
            default:          prdata = '0;
        endcase
    end

    sfir_front #(
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .data     (data),
        .cq_empty (cq_empty),
        .cq_pop   (cq_pop),
        .cq_item  (cq_item)
    );

    sfir_back #(
        .MAX_TAPS (MAX_TAPS),
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cq_empty (cq_empty),
        .cq_pop   (cq_pop),
        .cq_item  (cq_item),
        .res_push (res_push),
        .res_full (res_full),
        .res_item (res_item)
    );

    sfir_fifo #(
        .WIDTH ($bits(sfir_out_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_item),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

endmodule
